@@ rtl/ple_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the positional list engine.
// No dependencies; every other file imports this package.
package ple_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int QUEUE_DEPTH  = 2;
    localparam int OP_W         = 4;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 5;
    localparam int STATUS_W     = 3;
    localparam int EXT_W        = 8;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 4'd0,
        OP_INS_BACK  = 4'd1,
        OP_INS_AT    = 4'd2,
        OP_DEL_FRONT = 4'd3,
        OP_DEL_BACK  = 4'd4,
        OP_DEL_AT    = 4'd5,
        OP_SEARCH    = 4'd6,
        OP_LIST      = 4'd7,
        OP_LIST_REV  = 4'd8,
        OP_REVERSE   = 4'd9
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_BAD_POS   = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef struct packed {
        t_op                       op;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } t_req;

    typedef struct packed {
        t_status                   status;
        logic signed [VALUE_W-1:0] item_value;
        logic [POS_W-1:0]          item_position;
        logic [POS_W-1:0]          count;
        logic                      last;
    } t_rsp;

    function automatic t_rsp mk_rsp(t_status s, logic signed [VALUE_W-1:0] v,
                                    logic [POS_W-1:0] p, logic [POS_W-1:0] c,
                                    logic l);
        t_rsp r;
        r.status        = s;
        r.item_value    = v;
        r.item_position = p;
        r.count         = c;
        r.last          = l;
        return r;
    endfunction

endpackage

@@ rtl/ple_if.sv @@
`timescale 1ns / 1ps
// Request and response channel interfaces of the positional list engine.
// Depends on ple_pkg for field widths.
interface ple_req_if import ple_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;

    modport source (output valid, output op, output value, output position, input ready);
    modport sink   (input valid, input op, input value, input position, output ready);
endinterface

interface ple_rsp_if import ple_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] item_value;
    logic [POS_W-1:0]          item_position;
    logic [POS_W-1:0]          count;
    logic                      last;

    modport source (output valid, output status, output item_value, output item_position,
                    output count, output last, input ready);
    modport sink   (input valid, input status, input item_value, input item_position,
                    input count, input last, output ready);
endinterface

@@ rtl/positional_list_engine_unit.sv @@
`timescale 1ns / 1ps
// Positional list engine, top level: front end, request queue and list back end.
// Depends on ple_pkg, ple_if, ple_front, ple_queue and ple_back.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit values as linked nodes in a
// pool with a single read and a single write port. A request is taken from the queue
// in S_IDLE and decoded in S_DECIDE. Inserts at the front, and any request that ends
// in a status, answer from S_DECIDE; appends to a non-empty list also pass S_TAIL_LINK.
// Walks visit one node per cycle unless a stalled response holds them, bounded by that
// single node read port. Inserts and deletes walk to their position, other walks cover
// the whole list, and reverse listing then replays a buffer backwards in read and
// output steps. One request is worked at a time; a two-entry queue keeps requests
// flowing in while the back end is busy. Opcodes 10 to 15 are dropped.
module positional_list_engine_unit import ple_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ple_req_if.sink   i_req,
    ple_rsp_if.source o_rsp
);

    logic push_valid;
    logic push_ready;
    t_req push;
    logic pop_valid;
    logic pop_ready;
    t_req pop;

    ple_front u_front (
        .i_req        (i_req),
        .o_push_valid (push_valid),
        .o_push       (push),
        .i_push_ready (push_ready)
    );

    ple_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push       (push),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop        (pop),
        .i_pop_ready  (pop_ready)
    );

    ple_back #(.CAPACITY(CAPACITY)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (pop_valid),
        .i_req       (pop),
        .o_req_ready (pop_ready),
        .o_rsp       (o_rsp)
    );

endmodule

@@ rtl/ple_front.sv @@
`timescale 1ns / 1ps
// Request front end: decodes the opcode and drops unused codes.
// Depends on ple_pkg and ple_req_if.
module ple_front import ple_pkg::*; (
    ple_req_if.sink  i_req,
    output logic     o_push_valid,
    output t_req     o_push,
    input  logic     i_push_ready
);

    logic legal;

    assign legal            = (i_req.op <= OP_REVERSE);
    assign i_req.ready      = i_push_ready;
    assign o_push_valid     = i_req.valid && legal;
    assign o_push.op        = t_op'(i_req.op);
    assign o_push.value     = i_req.value;
    assign o_push.position  = i_req.position;

endmodule

@@ rtl/ple_queue.sv @@
`timescale 1ns / 1ps
// Short request queue between front end and list back end.
// Depends on ple_pkg.
module ple_queue import ple_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_req i_push,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_req o_pop,
    input  logic i_pop_ready
);

    localparam int PW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    t_req          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [FW-1:0] r_fill;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_fill != FW'(DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop        = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_mem[r_wr] <= i_push;
                r_wr        <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (push && !pop) begin
                r_fill <= r_fill + FW'(1);
            end else if (pop && !push) begin
                r_fill <= r_fill - FW'(1);
            end
        end
    end

endmodule

@@ rtl/ple_back.sv @@
`timescale 1ns / 1ps
// List back end: node pool, free map, walk sequencer and response register.
// Depends on ple_pkg and ple_rsp_if.
module ple_back import ple_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    input  t_req      i_req,
    output logic      o_req_ready,
    ple_rsp_if.source o_rsp
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK,
        S_TAIL_LINK,
        S_PREV_LINK,
        S_STACK_RD,
        S_STACK_OUT,
        S_FINAL
    } t_state;

    logic signed [VALUE_W-1:0] r_vals  [CAPACITY];
    logic [IW-1:0]             r_links [CAPACITY];
    logic signed [VALUE_W-1:0] r_stack [CAPACITY];

    t_state                    r_state, n_state;
    logic [IW-1:0]             r_head, n_head;
    logic [IW-1:0]             r_tail, n_tail;
    logic [CW-1:0]             r_count, n_count;
    logic [CAPACITY-1:0]       r_free, n_free;
    logic                      r_o_valid, n_o_valid;
    t_rsp                      r_rsp, n_rsp;
    t_op                       r_op, n_op;
    logic signed [VALUE_W-1:0] r_val, n_val;
    logic [POS_W-1:0]          r_pos, n_pos;
    logic [EXT_W-1:0]          r_at, n_at;
    logic [IW-1:0]             r_nd, n_nd;
    logic [IW-1:0]             r_node, n_node;
    logic [IW-1:0]             r_prev, n_prev;
    logic [CW-1:0]             r_k, n_k;
    logic [CW-1:0]             r_target, n_target;
    logic                      r_pend, n_pend;
    logic [CW-1:0]             r_pend_pos, n_pend_pos;

    logic signed [VALUE_W-1:0] r_rd_val;
    logic [IW-1:0]             r_rd_lnk;
    logic signed [VALUE_W-1:0] r_stk;

    logic [IW-1:0]             rd_addr;
    logic                      val_we;
    logic                      lnk_we;
    logic [IW-1:0]             lnk_wa;
    logic [IW-1:0]             lnk_wd;
    logic                      stk_we;
    logic [IW-1:0]             stk_addr;
    logic [IW-1:0]             free_idx;
    logic                      out_free;

    always_comb begin
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                free_idx = IW'(i);
            end
        end
    end

    assign out_free    = !r_o_valid || o_rsp.ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign stk_addr    = IW'(r_k - CW'(1));

    always_comb begin
        logic [EXT_W-1:0] n_e;
        logic [EXT_W-1:0] pos_e;
        logic [EXT_W-1:0] at_ins;
        logic [EXT_W-1:0] at_del;
        logic [POS_W-1:0] cnt;
        logic [POS_W-1:0] cnt_inc;
        logic [POS_W-1:0] cnt_dec;
        logic             at_end;
        logic             adv;
        logic             walk;
        logic             match;

        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_free     = r_free;
        n_o_valid  = r_o_valid && !o_rsp.ready;
        n_rsp      = r_rsp;
        n_op       = r_op;
        n_val      = r_val;
        n_pos      = r_pos;
        n_at       = r_at;
        n_nd       = r_nd;
        n_node     = r_node;
        n_prev     = r_prev;
        n_k        = r_k;
        n_target   = r_target;
        n_pend     = r_pend;
        n_pend_pos = r_pend_pos;
        rd_addr    = r_node;
        val_we     = 1'b0;
        lnk_we     = 1'b0;
        lnk_wa     = r_nd;
        lnk_wd     = '0;
        stk_we     = 1'b0;
        adv        = 1'b0;
        walk       = 1'b0;

        n_e     = EXT_W'(r_count);
        pos_e   = EXT_W'(r_pos);
        cnt     = POS_W'(r_count);
        cnt_inc = POS_W'(r_count + CW'(1));
        cnt_dec = POS_W'(r_count - CW'(1));
        at_end  = (r_k == r_target);
        match   = (r_rd_val == r_val);
        unique case (r_op)
            OP_INS_FRONT: at_ins = EXT_W'(1);
            OP_INS_BACK:  at_ins = n_e + EXT_W'(1);
            default:      at_ins = pos_e;
        endcase
        unique case (r_op)
            OP_DEL_FRONT: at_del = EXT_W'(1);
            OP_DEL_BACK:  at_del = n_e;
            default:      at_del = pos_e;
        endcase

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op    = i_req.op;
                    n_val   = i_req.value;
                    n_pos   = i_req.position;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    unique case (r_op) inside
                        OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                            n_at = at_ins;
                            if (r_op == OP_INS_AT &&
                                (pos_e == '0 || pos_e > n_e + EXT_W'(1))) begin
                                n_o_valid = 1'b1;
                                n_rsp     = mk_rsp(ST_BAD_POS, r_val, '0, cnt, 1'b1);
                            end else if (r_count == CW'(CAPACITY)) begin
                                n_o_valid = 1'b1;
                                n_rsp     = mk_rsp(ST_FULL, r_val, '0, cnt, 1'b1);
                            end else begin
                                n_free[free_idx] = 1'b0;
                                n_nd   = free_idx;
                                val_we = 1'b1;
                                lnk_wa = free_idx;
                                if (r_count == '0) begin
                                    lnk_we    = 1'b1;
                                    n_head    = free_idx;
                                    n_tail    = free_idx;
                                    n_count   = r_count + CW'(1);
                                    n_o_valid = 1'b1;
                                    n_rsp     = mk_rsp(ST_OK, r_val, POS_W'(at_ins), cnt_inc,
                                                       1'b1);
                                end else if (at_ins == EXT_W'(1)) begin
                                    lnk_we    = 1'b1;
                                    lnk_wd    = r_head;
                                    n_head    = free_idx;
                                    n_count   = r_count + CW'(1);
                                    n_o_valid = 1'b1;
                                    n_rsp     = mk_rsp(ST_OK, r_val, POS_W'(at_ins), cnt_inc,
                                                       1'b1);
                                end else if (at_ins == n_e + EXT_W'(1)) begin
                                    lnk_we  = 1'b1;
                                    n_state = S_TAIL_LINK;
                                end else begin
                                    walk     = 1'b1;
                                    n_target = CW'(at_ins - EXT_W'(1));
                                end
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_o_valid = 1'b1;
                                n_rsp     = mk_rsp(ST_EMPTY, '0, '0, '0, 1'b1);
                            end else begin
                                case (r_op) inside
                                    OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
                                        n_at = at_del;
                                        if (at_del == '0 || at_del > n_e) begin
                                            n_o_valid = 1'b1;
                                            n_rsp     = mk_rsp(ST_BAD_POS, '0, '0, cnt, 1'b1);
                                        end else begin
                                            walk     = 1'b1;
                                            n_target = CW'(at_del);
                                        end
                                    end
                                    OP_REVERSE: begin
                                        if (r_count == CW'(1)) begin
                                            n_o_valid = 1'b1;
                                            n_rsp     = mk_rsp(ST_OK, '0, '0, cnt, 1'b1);
                                        end else begin
                                            walk     = 1'b1;
                                            n_target = r_count;
                                        end
                                    end
                                    default: begin
                                        walk     = 1'b1;
                                        n_target = r_count;
                                        n_pend   = 1'b0;
                                    end
                                endcase
                            end
                        end
                    endcase
                    if (walk) begin
                        rd_addr = r_head;
                        n_node  = r_head;
                        n_prev  = r_head;
                        n_k     = CW'(1);
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                case (r_op) inside
                    OP_INS_AT: begin
                        if (at_end) begin
                            lnk_we  = 1'b1;
                            lnk_wa  = r_nd;
                            lnk_wd  = r_rd_lnk;
                            n_state = S_PREV_LINK;
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
                        if (!at_end) begin
                            adv = 1'b1;
                        end else if (out_free) begin
                            if (r_at == EXT_W'(1)) begin
                                if (r_count > CW'(1)) begin
                                    n_head = r_rd_lnk;
                                end
                            end else begin
                                lnk_we = 1'b1;
                                lnk_wa = r_prev;
                                lnk_wd = r_rd_lnk;
                                if (r_at == n_e) begin
                                    n_tail = r_prev;
                                end
                            end
                            if (r_count == CW'(1)) begin
                                n_head = '0;
                                n_tail = '0;
                            end
                            n_free[r_node] = 1'b1;
                            n_count   = r_count - CW'(1);
                            n_o_valid = 1'b1;
                            n_rsp     = mk_rsp(ST_OK, r_rd_val, POS_W'(r_at), cnt_dec, 1'b1);
                            n_state   = S_IDLE;
                        end
                    end
                    OP_SEARCH: begin
                        if (!(match && r_pend && !out_free)) begin
                            if (match && r_pend) begin
                                n_o_valid = 1'b1;
                                n_rsp     = mk_rsp(ST_OK, r_val, POS_W'(r_pend_pos), cnt,
                                                   1'b0);
                            end
                            if (match) begin
                                n_pend     = 1'b1;
                                n_pend_pos = r_k;
                            end
                            if (at_end) begin
                                n_state = S_FINAL;
                            end else begin
                                adv = 1'b1;
                            end
                        end
                    end
                    OP_LIST: begin
                        if (out_free) begin
                            n_o_valid = 1'b1;
                            n_rsp     = mk_rsp(ST_OK, r_rd_val, POS_W'(r_k), cnt, at_end);
                            if (at_end) begin
                                n_state = S_IDLE;
                            end else begin
                                adv = 1'b1;
                            end
                        end
                    end
                    OP_LIST_REV: begin
                        stk_we = 1'b1;
                        if (at_end) begin
                            n_state = S_STACK_RD;
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    OP_REVERSE: begin
                        lnk_we = 1'b1;
                        lnk_wa = r_node;
                        lnk_wd = (r_k == CW'(1)) ? '0 : r_prev;
                        if (at_end) begin
                            n_head  = r_node;
                            n_tail  = r_head;
                            n_state = S_FINAL;
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
                if (adv) begin
                    rd_addr = r_rd_lnk;
                    n_prev  = r_node;
                    n_node  = r_rd_lnk;
                    n_k     = r_k + CW'(1);
                end
            end
            S_TAIL_LINK: begin
                if (out_free) begin
                    lnk_we    = 1'b1;
                    lnk_wa    = r_tail;
                    lnk_wd    = r_nd;
                    n_tail    = r_nd;
                    n_count   = r_count + CW'(1);
                    n_o_valid = 1'b1;
                    n_rsp     = mk_rsp(ST_OK, r_val, POS_W'(r_at), cnt_inc, 1'b1);
                    n_state   = S_IDLE;
                end
            end
            S_PREV_LINK: begin
                if (out_free) begin
                    lnk_we    = 1'b1;
                    lnk_wa    = r_node;
                    lnk_wd    = r_nd;
                    n_count   = r_count + CW'(1);
                    n_o_valid = 1'b1;
                    n_rsp     = mk_rsp(ST_OK, r_val, POS_W'(r_at), cnt_inc, 1'b1);
                    n_state   = S_IDLE;
                end
            end
            S_STACK_RD: begin
                n_state = S_STACK_OUT;
            end
            S_STACK_OUT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_rsp     = mk_rsp(ST_OK, r_stk, POS_W'(r_k), cnt, r_k == CW'(1));
                    if (r_k == CW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k - CW'(1);
                        n_state = S_STACK_RD;
                    end
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                    if (r_op != OP_SEARCH) begin
                        n_rsp = mk_rsp(ST_OK, '0, '0, cnt, 1'b1);
                    end else if (r_pend) begin
                        n_rsp = mk_rsp(ST_OK, r_val, POS_W'(r_pend_pos), cnt, 1'b1);
                    end else begin
                        n_rsp = mk_rsp(ST_NOT_FOUND, r_val, '0, cnt, 1'b1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            r_vals[free_idx] <= r_val;
        end
        r_rd_val <= r_vals[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (lnk_we) begin
            r_links[lnk_wa] <= lnk_wd;
        end
        r_rd_lnk <= r_links[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_addr] <= r_rd_val;
        end
        r_stk <= r_stack[stk_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_free    <= {CAPACITY{1'b1}};
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_free    <= n_free;
            r_o_valid <= n_o_valid;
        end
        r_rsp      <= n_rsp;
        r_op       <= n_op;
        r_val      <= n_val;
        r_pos      <= n_pos;
        r_at       <= n_at;
        r_nd       <= n_nd;
        r_node     <= n_node;
        r_prev     <= n_prev;
        r_k        <= n_k;
        r_target   <= n_target;
        r_pend     <= n_pend;
        r_pend_pos <= n_pend_pos;
    end

    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.status        = r_rsp.status;
    assign o_rsp.item_value    = r_rsp.item_value;
    assign o_rsp.item_position = r_rsp.item_position;
    assign o_rsp.count         = r_rsp.count;
    assign o_rsp.last          = r_rsp.last;

endmodule

@@ rtl/ple_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the positional list engine and their bind.
// Depends on ple_pkg and positional_list_engine_unit.
module ple_checker import ple_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_rsp_valid,
    input logic                      i_rsp_ready,
    input logic [STATUS_W-1:0]       i_rsp_status,
    input logic signed [VALUE_W-1:0] i_rsp_item_value,
    input logic [POS_W-1:0]          i_rsp_item_position,
    input logic [POS_W-1:0]          i_rsp_count,
    input logic                      i_rsp_last
);

    a_quiet_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_rsp_valid)
        else $error("response valid right after reset");

    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == ST_EMPTY |->
            i_rsp_count == '0 && i_rsp_item_position == '0 && i_rsp_last)
        else $error("empty status with nonzero fields");

    a_inner_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_last |->
            i_rsp_status == ST_OK && i_rsp_item_position != '0 &&
            i_rsp_item_position <= i_rsp_count)
        else $error("non-final response without a valid position");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_item_value) && $stable(i_rsp_last))
        else $error("stalled response changed");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> int'(i_rsp_count) <= CAPACITY)
        else $error("response count above capacity");

endmodule

bind positional_list_engine_unit ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_rsp_status        (o_rsp.status),
    .i_rsp_item_value    (o_rsp.item_value),
    .i_rsp_item_position (o_rsp.item_position),
    .i_rsp_count         (o_rsp.count),
    .i_rsp_last          (o_rsp.last)
);
